### src/mutex_priority_inheritance_macros.svh
// Assertion macros shared by the mutex RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef MUTEX_PRIORITY_INHERITANCE_MACROS_SVH
`define MUTEX_PRIORITY_INHERITANCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mutex assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mutex assertion failed");

`endif

### src/mpi_pkg.sv
`timescale 1ns / 1ps

package mpi_pkg;

  // Number of task ids the lock serves; the id field is sized from it.
  localparam int TASK_COUNT = 16;

  // Field widths fixed by the request and response formats.
  localparam int ID_W   = $clog2(TASK_COUNT);
  localparam int PRIO_W = 8;

  // Default depth of the waiter queue.
  localparam int WAIT_DEPTH_DEFAULT = 8;

  typedef enum logic {
    REQ_TAKE = 1'b0,
    REQ_GIVE = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_HANDOVER  = 3'd3,
    ST_NOT_OWNER = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef struct packed {
    req_kind_t         req_type;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] task_priority;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic              owner_valid;
    logic [ID_W-1:0]   owner_id;
    logic [PRIO_W-1:0] owner_priority;
    logic              woken_valid;
    logic [ID_W-1:0]   woken_id;
    logic [PRIO_W-1:0] restore_priority;
    logic              switch_request;
  } rsp_t;

endpackage

### src/mpi_ram.sv
`timescale 1ns / 1ps

module mpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/mutex_priority_inheritance.sv
`timescale 1ns / 1ps
// Hardware mutex with priority inheritance and a FIFO of waiting tasks. Each
// request beat takes or gives the lock for one task; a lower priority number is
// more urgent. A waiter that is more urgent than the holder raises the holder's
// effective priority, and a give by the holder restores its base priority and
// either frees the lock or hands it to the oldest waiter. Every request beat
// produces exactly one response beat. The block takes one request per cycle
// while req_stall is low. A request passes the request register, where the
// lock state is read and updated, and then the response register. The waiter
// queue sits in a RAM of WAIT_DEPTH entries whose head is read ahead from the
// next read pointer, with a bypass for a head written in the previous cycle.
`include "mutex_priority_inheritance_macros.svh"

module mutex_priority_inheritance
  import mpi_pkg::*;
#(
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int PTR_W = $clog2(WAIT_DEPTH);
  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
  localparam int ENT_W = ID_W + PRIO_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WAIT_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WAIT_DEPTH);

  // Request register and pipeline control.
  logic s1_valid;
  req_t s1_req;
  logic s1_adv;
  logic fire;

  // Lock state.
  logic              locked, locked_next;
  logic [ID_W-1:0]   holder_id, holder_id_next;
  logic [PRIO_W-1:0] base_priority, base_priority_next;
  logic [PRIO_W-1:0] effective_priority, effective_priority_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]  waiter_count, waiter_count_next;

  // Waiter queue storage.
  logic              push;
  logic [ENT_W-1:0]  ram_rdata;
  logic              head_bypass;
  logic [ENT_W-1:0]  head_bypass_data;
  logic [ENT_W-1:0]  head;
  logic [ID_W-1:0]   head_id;
  logic [PRIO_W-1:0] head_prio;

  rsp_t rsp_next;

  assign s1_adv    = !rsp_valid || !rsp_stall;
  assign fire      = s1_valid && s1_adv;
  assign req_stall = s1_valid && !s1_adv;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
    if (req_valid && !req_stall) begin
      s1_req <= req;
    end
  end

  // Head of the waiter queue, with the entry written last cycle taking over.
  assign head      = head_bypass ? head_bypass_data : ram_rdata;
  assign head_id   = head[ENT_W-1 -: ID_W];
  assign head_prio = head[PRIO_W-1:0];

  mpi_ram #(
    .WIDTH (ENT_W),
    .DEPTH (WAIT_DEPTH)
  ) u_waiters (
    .clk   (clk),
    .we    (push),
    .waddr (wr_ptr),
    .wdata ({s1_req.task_id, s1_req.task_priority}),
    .raddr (rd_ptr_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head_bypass <= 1'b0;
    end else begin
      head_bypass <= push && (wr_ptr == rd_ptr_next);
    end
    head_bypass_data <= {s1_req.task_id, s1_req.task_priority};
  end

  // Lock decision for the request in the request register.
  always_comb begin
    locked_next             = locked;
    holder_id_next          = holder_id;
    base_priority_next      = base_priority;
    effective_priority_next = effective_priority;
    rd_ptr_next             = rd_ptr;
    wr_ptr_next             = wr_ptr;
    waiter_count_next       = waiter_count;
    push                    = 1'b0;
    rsp_next                = '0;
    rsp_next.status         = ST_NOT_OWNER;

    if (s1_req.req_type == REQ_TAKE) begin
      if (!locked) begin
        locked_next             = 1'b1;
        holder_id_next          = s1_req.task_id;
        base_priority_next      = s1_req.task_priority;
        effective_priority_next = s1_req.task_priority;
        rsp_next.status         = ST_GRANTED;
      end else if (waiter_count == FULL_CNT) begin
        rsp_next.status = ST_FULL;
      end else begin
        push              = fire;
        wr_ptr_next       = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
        waiter_count_next = waiter_count + 1'b1;
        if (s1_req.task_priority < effective_priority) begin
          effective_priority_next = s1_req.task_priority;
        end
        rsp_next.status         = ST_BLOCKED;
        rsp_next.switch_request = 1'b1;
      end
    end else if (locked && holder_id == s1_req.task_id) begin
      rsp_next.restore_priority = base_priority;
      if (waiter_count == '0) begin
        locked_next             = 1'b0;
        holder_id_next          = '0;
        base_priority_next      = '0;
        effective_priority_next = '0;
        rsp_next.status         = ST_RELEASED;
      end else begin
        holder_id_next          = head_id;
        base_priority_next      = head_prio;
        effective_priority_next = head_prio;
        rd_ptr_next             = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
        waiter_count_next       = waiter_count - 1'b1;
        rsp_next.status         = ST_HANDOVER;
        rsp_next.woken_valid    = 1'b1;
        rsp_next.woken_id       = head_id;
        rsp_next.switch_request = 1'b1;
      end
    end

    rsp_next.owner_valid    = locked_next;
    rsp_next.owner_id       = locked_next ? holder_id_next : '0;
    rsp_next.owner_priority = locked_next ? effective_priority_next : '0;

    // Hold the next read pointer unless the request actually moves on this cycle.
    if (!fire) begin
      rd_ptr_next = rd_ptr;
    end
  end

  // Lock state register, updated only when a request moves to the response.
  always_ff @(posedge clk) begin
    if (rst) begin
      locked             <= 1'b0;
      holder_id          <= '0;
      base_priority      <= '0;
      effective_priority <= '0;
      rd_ptr             <= '0;
      wr_ptr             <= '0;
      waiter_count       <= '0;
    end else if (fire) begin
      locked             <= locked_next;
      holder_id          <= holder_id_next;
      base_priority      <= base_priority_next;
      effective_priority <= effective_priority_next;
      rd_ptr             <= rd_ptr_next;
      wr_ptr             <= wr_ptr_next;
      waiter_count       <= waiter_count_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= s1_valid;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  // A free lock never has waiters behind it.
  `MPI_ASSERT_SAME(a_free_no_waiters, !locked, waiter_count == '0)
  // The queue never holds more than its depth.
  `MPI_ASSERT_SAME(a_count_bound, 1'b1, waiter_count <= FULL_CNT)
  // A handover always wakes a waiter and asks for a switch.
  `MPI_ASSERT_SAME(a_handover_wakes, rsp_valid && rsp.status == ST_HANDOVER,
                   rsp.woken_valid && rsp.switch_request && rsp.owner_valid)
  // A push always leaves the lock held with at least one waiter.
  `MPI_ASSERT_NEXT(a_push_counts, push, locked && waiter_count != '0)

endmodule
